// ===== sv/mjfs_pkg.sv =====
// Shared types and constants for the merged JPEG frame split detector.
// Used by the channel interfaces and every module of the block; no dependencies.
package mjfs_pkg;

  localparam int HISTORY_DEPTH = 3;
  localparam int HIST_PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int MEDIAN_IDX    = (HISTORY_DEPTH / 2) + (HISTORY_DEPTH % 2) - 1;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 24;

  localparam logic [BYTE_W-1:0] SOI_FIRST        = 8'hFF;
  localparam logic [BYTE_W-1:0] SOI_SECOND       = 8'hD8;
  localparam logic [LEN_W-1:0]  DEFAULT_EXPECTED = 24'd250000;

  // One byte request as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              last_byte;
  } beat_t;

  // Verdict for one frame
  typedef struct packed {
    logic             oversized;
    logic             marker_found;
    logic [LEN_W-1:0] split_offset;
    logic [LEN_W-1:0] typical_size;
  } verdict_t;

endpackage

// ===== sv/mjfs_if.sv =====
// Valid/ready channel interfaces for byte requests and frame verdicts.
// Depends on mjfs_pkg for field widths.
interface mjfs_in_if;
  logic                         valid;
  logic                         ready;
  logic [mjfs_pkg::BYTE_W-1:0]  data_byte;
  logic [mjfs_pkg::LEN_W-1:0]   frame_length;
  logic                         last_byte;

  modport source (output valid, output data_byte, output frame_length, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_length, input last_byte,
                  output ready);
endinterface

interface mjfs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        oversized;
  logic                        marker_found;
  logic [mjfs_pkg::LEN_W-1:0]  split_offset;
  logic [mjfs_pkg::LEN_W-1:0]  typical_size;

  modport source (output valid, output oversized, output marker_found, output split_offset,
                  output typical_size, input ready);
  modport sink   (input valid, input oversized, input marker_found, input split_offset,
                  input typical_size, output ready);
endinterface

// ===== sv/mjfs_history.sv =====
// Size history: insertion with the two-pass swap reorder and median pick.
// Holds the history entries, pointer and default size register; uses mjfs_pkg.
module mjfs_history (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mjfs_pkg::LEN_W-1:0]  cfg_data,
  input  logic                        push,
  input  logic [mjfs_pkg::LEN_W-1:0]  frame_length,
  output logic [mjfs_pkg::LEN_W-1:0]  expected
);

  logic [mjfs_pkg::LEN_W-1:0]      hist      [mjfs_pkg::HISTORY_DEPTH];
  logic [mjfs_pkg::LEN_W-1:0]      hist_next [mjfs_pkg::HISTORY_DEPTH];
  logic [mjfs_pkg::HIST_PTR_W-1:0] ptr;
  logic [mjfs_pkg::HIST_PTR_W-1:0] ptr_next;
  logic [mjfs_pkg::LEN_W-1:0]      default_expected;

  always_comb begin
    logic [mjfs_pkg::HIST_PTR_W-1:0] p;
    logic [mjfs_pkg::LEN_W-1:0]      tmp;
    tmp = '0;
    if (mjfs_pkg::HIST_CNT_W'(ptr) >= mjfs_pkg::HIST_CNT_W'(mjfs_pkg::HISTORY_DEPTH)) begin
      p = '0;
    end else begin
      p = ptr;
    end
    for (int i = 0; i < mjfs_pkg::HISTORY_DEPTH; i++) begin
      hist_next[i] = (i == int'(p)) ? frame_length : hist[i];
    end
    // forward pass from the new entry; zeros move up as well
    for (int i = 1; i < mjfs_pkg::HISTORY_DEPTH; i++) begin
      if (i > int'(p) &&
          (hist_next[i] < hist_next[i-1] || hist_next[i] == '0)) begin
        tmp            = hist_next[i];
        hist_next[i]   = hist_next[i-1];
        hist_next[i-1] = tmp;
      end
    end
    // backward pass down to the first entry
    for (int i = mjfs_pkg::HISTORY_DEPTH - 2; i >= 0; i--) begin
      if (i < int'(p) &&
          (hist_next[i] > hist_next[i+1] || hist_next[i] == '0)) begin
        tmp            = hist_next[i];
        hist_next[i]   = hist_next[i+1];
        hist_next[i+1] = tmp;
      end
    end
    if (int'(p) + 1 == mjfs_pkg::HISTORY_DEPTH) begin
      ptr_next = '0;
    end else begin
      ptr_next = p + mjfs_pkg::HIST_PTR_W'(1);
    end
    expected = (hist_next[mjfs_pkg::MEDIAN_IDX] != '0) ?
               hist_next[mjfs_pkg::MEDIAN_IDX] : default_expected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr              <= '0;
      default_expected <= mjfs_pkg::DEFAULT_EXPECTED;
      for (int i = 0; i < mjfs_pkg::HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        default_expected <= cfg_data;
      end
      if (push) begin
        ptr <= ptr_next;
        for (int i = 0; i < mjfs_pkg::HISTORY_DEPTH; i++) begin
          hist[i] <= hist_next[i];
        end
      end
    end
  end

endmodule

// ===== sv/mjfs_scan.sv =====
// Per-frame byte scanner: offset count, header check, oversize test and
// second start-of-image search. Uses mjfs_pkg; expected size comes from mjfs_history.
module mjfs_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  mjfs_pkg::beat_t             beat,
  input  logic [mjfs_pkg::LEN_W-1:0]  expected_new,
  output logic                        first,
  output mjfs_pkg::verdict_t          verdict
);

  logic [mjfs_pkg::LEN_W-1:0]  byte_offset, byte_offset_next;
  logic [mjfs_pkg::BYTE_W-1:0] previous_byte;
  logic                        header_ok, header_ok_next;
  logic                        search_enabled, search_enabled_next;
  logic                        found_flag, found_flag_next;
  logic [mjfs_pkg::LEN_W-1:0]  found_offset, found_offset_next;
  logic [mjfs_pkg::LEN_W-1:0]  current_expected, current_expected_next;

  logic                        pair_seen;
  logic [mjfs_pkg::LEN_W-1:0]  pos;
  logic [mjfs_pkg::LEN_W+1:0]  len3;
  logic [mjfs_pkg::LEN_W:0]    limit;
  logic                        in_window;
  logic                        hit;

  assign first     = (byte_offset == '0);
  assign pair_seen = (previous_byte == mjfs_pkg::SOI_FIRST) &&
                     (beat.data_byte == mjfs_pkg::SOI_SECOND);
  assign pos       = byte_offset - mjfs_pkg::LEN_W'(1);
  assign len3      = {2'b00, beat.frame_length} + {1'b0, beat.frame_length, 1'b0};
  assign in_window = (pos >= {1'b0, len3[mjfs_pkg::LEN_W+1:3]}) &&
                     (pos < len3[mjfs_pkg::LEN_W+1:2]);
  // floor(3e/2) = e + floor(e/2)
  assign limit     = {1'b0, expected_new} + {2'b00, expected_new[mjfs_pkg::LEN_W-1:1]};

  always_comb begin
    header_ok_next        = header_ok;
    search_enabled_next   = search_enabled;
    found_flag_next       = found_flag;
    found_offset_next     = found_offset;
    current_expected_next = current_expected;
    priority if (first) begin
      current_expected_next = expected_new;
      search_enabled_next   = {1'b0, beat.frame_length} > limit;
      header_ok_next        = 1'b0;
      found_flag_next       = 1'b0;
      found_offset_next     = '0;
    end else if (byte_offset == mjfs_pkg::LEN_W'(1)) begin
      header_ok_next = pair_seen;
    end else if (header_ok && search_enabled && !found_flag && pair_seen && in_window) begin
      found_flag_next   = 1'b1;
      found_offset_next = pos;
    end else begin
      found_flag_next = found_flag;
    end

    if (beat.last_byte) begin
      byte_offset_next = '0;
    end else if (byte_offset != '1) begin
      byte_offset_next = byte_offset + mjfs_pkg::LEN_W'(1);
    end else begin
      byte_offset_next = byte_offset;
    end

    hit                  = found_flag_next && search_enabled_next && header_ok_next;
    verdict.oversized    = search_enabled_next;
    verdict.marker_found = hit;
    verdict.split_offset = hit ? found_offset_next : '0;
    verdict.typical_size = current_expected_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      previous_byte    <= '0;
      header_ok        <= 1'b0;
      search_enabled   <= 1'b0;
      found_flag       <= 1'b0;
      found_offset     <= '0;
      current_expected <= '0;
    end else if (fire) begin
      byte_offset      <= byte_offset_next;
      previous_byte    <= beat.data_byte;
      header_ok        <= header_ok_next;
      search_enabled   <= search_enabled_next;
      found_flag       <= found_flag_next;
      found_offset     <= found_offset_next;
      current_expected <= current_expected_next;
    end
  end

endmodule

// ===== sv/merged_jpeg_frame_split_detector_core.sv =====
// Top level of the merged JPEG frame split detector: input register, scanner,
// size history and verdict register. Uses mjfs_pkg, mjfs_if, mjfs_history, mjfs_scan.
//
//   channel  | dir | payload                                             | handshake
//   in_ch    | in  | data_byte, frame_length, last_byte                  | valid/ready
//   out_ch   | out | oversized, marker_found, split_offset, typical_size | valid/ready
//   cfg      | in  | cfg_data (default expected size)                    | cfg_we
//
// One byte request is taken per cycle unless a last byte waits on a full verdict
// register. A byte is registered, then processed into the frame state; the verdict
// for a frame is loaded into the verdict register when its last byte is processed.
// Only last bytes wait on a full verdict register, so a stalled out_ch holds back
// the stream only at a frame end. Synchronous reset clears the valid flags, the
// scanner and the history and sets the default size to 250000.
module merged_jpeg_frame_split_detector_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mjfs_pkg::LEN_W-1:0]  cfg_data,
  mjfs_in_if.sink                     in_ch,
  mjfs_out_if.source                  out_ch
);

  mjfs_pkg::beat_t            s1_beat;
  logic                       s1_valid;
  logic                       out_free;
  logic                       s1_fire;
  logic                       first;
  logic [mjfs_pkg::LEN_W-1:0] expected_new;
  mjfs_pkg::verdict_t         verdict;
  mjfs_pkg::verdict_t         out_q;
  logic                       out_valid;

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && (!s1_beat.last_byte || out_free);
  assign in_ch.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_beat.data_byte    <= in_ch.data_byte;
      s1_beat.frame_length <= in_ch.frame_length;
      s1_beat.last_byte    <= in_ch.last_byte;
    end
  end

  mjfs_history u_history (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .push         (s1_fire && first),
    .frame_length (s1_beat.frame_length),
    .expected     (expected_new)
  );

  mjfs_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_fire),
    .beat         (s1_beat),
    .expected_new (expected_new),
    .first        (first),
    .verdict      (verdict)
  );

  // load the verdict on a frame end, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_beat.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_beat.last_byte) begin
      out_q <= verdict;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.oversized    = out_q.oversized;
  assign out_ch.marker_found = out_q.marker_found;
  assign out_ch.split_offset = out_q.split_offset;
  assign out_ch.typical_size = out_q.typical_size;

  a_mid_frame_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_beat.last_byte |-> s1_fire)
    else $error("mid-frame byte held back");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_beat.last_byte))
    else $error("verdict without a last byte");

  a_marker_needs_oversize: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.marker_found |-> out_q.oversized)
    else $error("marker reported on a frame that is not oversized");

  a_offset_zero_no_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.marker_found |-> out_q.split_offset == '0)
    else $error("split offset set without a marker");

endmodule

// ===== dv/mjfs_verdict_checker.sv =====
// Frame verdict checker for the merged JPEG frame split detector.
// Watches the byte and verdict channels, predicts each verdict and compares it.
// Depends on mjfs_pkg and the channel interfaces in mjfs_if.
module mjfs_verdict_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mjfs_pkg::LEN_W-1:0] cfg_data,
  mjfs_in_if                         in_ch,
  mjfs_out_if                        out_ch,
  output int                         outstanding,
  output int                         fail_count
);

  logic [mjfs_pkg::LEN_W-1:0]  default_size;
  logic [mjfs_pkg::LEN_W-1:0]  size_hist [mjfs_pkg::HISTORY_DEPTH];
  int                          hist_ptr;
  logic [mjfs_pkg::LEN_W-1:0]  byte_pos;
  logic [mjfs_pkg::BYTE_W-1:0] last_seen;
  logic                        soi_header;
  logic                        too_big;
  logic                        split_hit;
  logic [mjfs_pkg::LEN_W-1:0]  split_at;
  logic [mjfs_pkg::LEN_W-1:0]  expected_now;
  mjfs_pkg::verdict_t          frame_verdicts [$];

  always @(posedge clk) begin : track
    logic [mjfs_pkg::LEN_W-1:0]  len;
    logic [mjfs_pkg::LEN_W-1:0]  tmp;
    logic [mjfs_pkg::LEN_W-1:0]  median;
    logic [mjfs_pkg::BYTE_W-1:0] b;
    longint unsigned             win_lo;
    longint unsigned             win_hi;
    longint unsigned             pos;
    int                          p;
    int                          nbad;
    mjfs_pkg::verdict_t          want;
    if (rst) begin
      default_size = mjfs_pkg::DEFAULT_EXPECTED;
      foreach (size_hist[i]) size_hist[i] = '0;
      hist_ptr     = 0;
      byte_pos     = '0;
      last_seen    = '0;
      soi_header   = 1'b0;
      too_big      = 1'b0;
      split_hit    = 1'b0;
      split_at     = '0;
      expected_now = '0;
      frame_verdicts.delete();
      outstanding <= 0;
      fail_count  <= 0;
    end else begin
      nbad = 0;
      if (cfg_we) default_size = cfg_data;

      if (in_ch.valid && in_ch.ready) begin
        b   = in_ch.data_byte;
        len = in_ch.frame_length;
        if (byte_pos == 0) begin
          p = (hist_ptr >= mjfs_pkg::HISTORY_DEPTH) ? 0 : hist_ptr;
          size_hist[p] = len;
          // forward pass from the new entry, then backward to the start; zeros travel too
          for (int i = p + 1; i < mjfs_pkg::HISTORY_DEPTH; i++) begin
            if (size_hist[i] < size_hist[i-1] || size_hist[i] == 0) begin
              tmp            = size_hist[i];
              size_hist[i]   = size_hist[i-1];
              size_hist[i-1] = tmp;
            end
          end
          for (int i = p - 1; i >= 0; i--) begin
            if (size_hist[i] > size_hist[i+1] || size_hist[i] == 0) begin
              tmp            = size_hist[i];
              size_hist[i]   = size_hist[i+1];
              size_hist[i+1] = tmp;
            end
          end
          hist_ptr     = (p + 1) % mjfs_pkg::HISTORY_DEPTH;
          median       = size_hist[mjfs_pkg::MEDIAN_IDX];
          expected_now = (median != 0) ? median : default_size;
          too_big      = 64'(len) > (64'd3 * 64'(expected_now)) / 64'd2;
          soi_header   = 1'b0;
          split_hit    = 1'b0;
          split_at     = '0;
        end else if (byte_pos == 1) begin
          soi_header = (last_seen == mjfs_pkg::SOI_FIRST && b == mjfs_pkg::SOI_SECOND);
        end else if (soi_header && too_big && !split_hit &&
                     last_seen == mjfs_pkg::SOI_FIRST && b == mjfs_pkg::SOI_SECOND) begin
          // window bounds follow the length carried by the byte completing the pair
          pos    = 64'(byte_pos) - 64'd1;
          win_lo = (64'd3 * 64'(len)) / 64'd8;
          win_hi = (64'd3 * 64'(len)) / 64'd4;
          if (pos >= win_lo && pos < win_hi) begin
            split_hit = 1'b1;
            split_at  = byte_pos - mjfs_pkg::LEN_W'(1);
          end
        end
        last_seen = b;

        if (in_ch.last_byte) begin
          want.oversized    = too_big;
          want.marker_found = split_hit && too_big && soi_header;
          want.split_offset = want.marker_found ? split_at : '0;
          want.typical_size = expected_now;
          frame_verdicts.push_back(want);
          byte_pos = '0;
        end else if (byte_pos != '1) begin
          byte_pos++;
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (frame_verdicts.size() == 0) begin
          $error("verdict arrived with no frame outstanding");
          nbad = 1;
        end else begin
          want = frame_verdicts.pop_front();
          if (out_ch.oversized !== want.oversized) begin
            $error("oversized: expected %0d, got %0d", want.oversized, out_ch.oversized);
            nbad++;
          end
          if (out_ch.marker_found !== want.marker_found) begin
            $error("marker_found: expected %0d, got %0d", want.marker_found,
                   out_ch.marker_found);
            nbad++;
          end
          if (out_ch.split_offset !== want.split_offset) begin
            $error("split_offset: expected %0d, got %0d", want.split_offset,
                   out_ch.split_offset);
            nbad++;
          end
          if (out_ch.typical_size !== want.typical_size) begin
            $error("typical_size: expected %0d, got %0d", want.typical_size,
                   out_ch.typical_size);
            nbad++;
          end
        end
      end

      outstanding <= frame_verdicts.size();
      fail_count  <= fail_count + nbad;
    end
  end

endmodule

// ===== dv/tb_merged_jpeg_frame_split_detector_core.sv =====
// Testbench top for the merged JPEG frame split detector: clock, reset, byte and
// configuration stimulus, verdict back-pressure and the final verdict.
// Depends on mjfs_pkg, mjfs_if, the detector core and mjfs_verdict_checker.
module tb_merged_jpeg_frame_split_detector_core;

  localparam int ITEM_TARGET = 1850;
  localparam int PHASES      = 8;
  localparam int STALL_LIMIT = 2000;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [mjfs_pkg::LEN_W-1:0] cfg_data;

  bit  quiet;
  bit  gappy;
  int  sent;
  int  stalled_cycles;
  int  outstanding;
  int  fail_count;

  logic [mjfs_pkg::BYTE_W-1:0] frame_bytes [$];
  logic [mjfs_pkg::LEN_W-1:0]  frame_lengths [$];

  mjfs_in_if  in_ch ();
  mjfs_out_if out_ch ();

  merged_jpeg_frame_split_detector_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  mjfs_verdict_checker verdict_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Verdict back-pressure: random stall bursts, none once the run goes quiet
  initial begin : verdict_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [mjfs_pkg::BYTE_W-1:0] b,
                           input logic [mjfs_pkg::LEN_W-1:0] len, input logic last);
    if (gappy && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.frame_length <= len;
    in_ch.last_byte    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame();
    gappy = !quiet && $urandom_range(0, 3) != 0;
    for (int k = 0; k < frame_bytes.size(); k++)
      send_byte(frame_bytes[k], frame_lengths[k], k == frame_bytes.size() - 1);
  endtask

  task automatic fill_lengths(input logic [mjfs_pkg::LEN_W-1:0] len);
    frame_lengths.delete();
    foreach (frame_bytes[k]) frame_lengths.push_back(len);
  endtask

  // Hold the byte stream, drain every verdict, then write the default size
  task automatic write_default_size(input logic [mjfs_pkg::LEN_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Frame shaped like camera output: sizes near the running base, mostly with an
  // FF D8 header and start markers placed in, at the edges of, or outside the window
  task automatic build_camera_frame(input int base);
    int                         n;
    int                         wlo;
    int                         whi;
    int                         pos;
    int                         pick;
    logic [mjfs_pkg::LEN_W-1:0] len;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = mjfs_pkg::LEN_W'(base + int'($urandom_range(0, base / 2)));
    else len = mjfs_pkg::LEN_W'(base * 2 + int'($urandom_range(0, base * 2)));
    pick = $urandom_range(0, 7);
    if (pick == 0) n = $urandom_range(1, len);
    else if (pick == 1) n = int'(len) + int'($urandom_range(1, 8));
    else n = int'(len);

    frame_bytes.delete();
    frame_lengths.delete();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) frame_bytes.push_back(mjfs_pkg::SOI_FIRST);
      else if (pick == 1) frame_bytes.push_back(mjfs_pkg::SOI_SECOND);
      else frame_bytes.push_back(mjfs_pkg::BYTE_W'($urandom_range(0, 255)));
      frame_lengths.push_back(len);
    end
    if ($urandom_range(0, 9) != 0) begin
      frame_bytes[0] = mjfs_pkg::SOI_FIRST;
      if (n > 1) frame_bytes[1] = mjfs_pkg::SOI_SECOND;
    end

    wlo = 3 * int'(len) / 8;
    whi = 3 * int'(len) / 4;
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 2);
      if (pick == 0 && whi > wlo) begin
        pos = $urandom_range(wlo, whi - 1);
      end else if (pick == 1) begin
        case ($urandom_range(0, 3))
          0:       pos = wlo - 1;
          1:       pos = wlo;
          2:       pos = whi - 1;
          default: pos = whi;
        endcase
      end else begin
        pos = $urandom_range(0, n - 1);
      end
      if (pos >= 0 && pos + 1 < n) begin
        frame_bytes[pos]     = mjfs_pkg::SOI_FIRST;
        frame_bytes[pos + 1] = mjfs_pkg::SOI_SECOND;
      end
    end

    // change the carried length part-way through now and then
    if (n > 1 && $urandom_range(0, 7) == 0) begin
      pos = $urandom_range(1, n - 1);
      len = mjfs_pkg::LEN_W'($urandom_range(1, 2 * int'(len) + 4));
      for (int k = pos; k < n; k++) frame_lengths[k] = len;
    end
  endtask

  task automatic build_noise_frame();
    int                         n;
    logic [mjfs_pkg::LEN_W-1:0] len;
    n = $urandom_range(1, 24);
    if ($urandom_range(0, 1) == 0) len = mjfs_pkg::LEN_W'($urandom_range(1, 24'hFFFFFF));
    else len = mjfs_pkg::LEN_W'($urandom_range(1, 64));
    frame_bytes.delete();
    frame_lengths.delete();
    for (int k = 0; k < n; k++) begin
      frame_bytes.push_back(mjfs_pkg::BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        frame_lengths.push_back(mjfs_pkg::LEN_W'($urandom_range(1, 24'hFFFFFF)));
      else frame_lengths.push_back(len);
    end
  endtask

  initial begin : byte_source
    int                         base;
    logic [mjfs_pkg::LEN_W-1:0] setting;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= '0;
    in_ch.frame_length <= '0;
    in_ch.last_byte    <= 1'b0;
    quiet = 1'b0;
    gappy = 1'b0;
    sent  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one-byte frame against the reset default size
    frame_bytes = '{mjfs_pkg::SOI_FIRST};
    fill_lengths(24'd1);
    send_frame();

    // zero default: empty median gives zero expected size, pair at the window start
    write_default_size(24'd0);
    frame_bytes = '{mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND, 8'h00, mjfs_pkg::SOI_FIRST,
                    mjfs_pkg::SOI_SECOND, 8'h00, 8'h00, 8'h00};
    fill_lengths(24'd8);
    send_frame();

    // bad header at the largest length
    write_default_size(24'hFFFFFF);
    frame_bytes = '{8'h00, mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND};
    fill_lengths(24'hFFFFFF);
    send_frame();

    // length drops after the header, so the window follows the later length
    write_default_size(24'd1);
    frame_bytes = '{mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND, mjfs_pkg::SOI_FIRST,
                    mjfs_pkg::SOI_SECOND, mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND};
    fill_lengths(24'd40);
    for (int k = 2; k < 6; k++) frame_lengths[k] = 24'd4;
    send_frame();

    // short frame of a huge claimed length, repeated FF before the pair
    frame_bytes = '{mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND, mjfs_pkg::SOI_FIRST,
                    mjfs_pkg::SOI_FIRST, mjfs_pkg::SOI_SECOND};
    fill_lengths(24'h800000);
    send_frame();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = mjfs_pkg::DEFAULT_EXPECTED;
        1:       setting = 24'hFFFFFF;
        2:       setting = 24'd0;
        3:       setting = 24'd1;
        default: setting = mjfs_pkg::LEN_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      write_default_size(setting);
      base = $urandom_range(4, 24);
      while (sent < (ph + 1) * ITEM_TARGET / PHASES) begin
        if (sent > ITEM_TARGET * 85 / 100) quiet = 1'b1;
        if ($urandom_range(0, 9) < 8) build_camera_frame(base);
        else build_noise_frame();
        send_frame();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
